@@ sv/sbad_pkg.sv @@
// Shared types, target codes and address map constants for the system bus
// address decoder. No dependencies.
package sbad_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int OFS_W  = 26;
  localparam int TGT_W  = 5;
  localparam int MIR_W  = 24;

  localparam int DEF_BOARD_RAM_BYTES = 262144;
  localparam int DEF_CHIP_RAM_BYTES  = 32768;
  localparam int DEF_CART_RAM_BYTES  = 65536;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  // target codes
  localparam logic [TGT_W-1:0] TGT_UNMAPPED = 5'd0;
  localparam logic [TGT_W-1:0] TGT_BOOTROM  = 5'd1;
  localparam logic [TGT_W-1:0] TGT_BOARDRAM = 5'd2;
  localparam logic [TGT_W-1:0] TGT_CHIPRAM  = 5'd3;
  localparam logic [TGT_W-1:0] TGT_VIDREG   = 5'd4;
  localparam logic [TGT_W-1:0] TGT_DMA      = 5'd5;
  localparam logic [TGT_W-1:0] TGT_TIMER    = 5'd6;
  localparam logic [TGT_W-1:0] TGT_KEYSTAT  = 5'd7;
  localparam logic [TGT_W-1:0] TGT_KEYCTL   = 5'd8;
  localparam logic [TGT_W-1:0] TGT_IRQEN    = 5'd9;
  localparam logic [TGT_W-1:0] TGT_IRQFLAG  = 5'd10;
  localparam logic [TGT_W-1:0] TGT_WAIT     = 5'd11;
  localparam logic [TGT_W-1:0] TGT_IME      = 5'd12;
  localparam logic [TGT_W-1:0] TGT_POST     = 5'd13;
  localparam logic [TGT_W-1:0] TGT_HALT     = 5'd14;
  localparam logic [TGT_W-1:0] TGT_MEMCTL   = 5'd15;
  localparam logic [TGT_W-1:0] TGT_VIDMEM   = 5'd16;
  localparam logic [TGT_W-1:0] TGT_ROM      = 5'd17;
  localparam logic [TGT_W-1:0] TGT_CARTRAM  = 5'd18;

  // address map
  localparam logic [ADDR_W-1:0] BOOTROM_END  = 32'h0000_4000;
  localparam logic [ADDR_W-1:0] BOARDRAM_LO  = 32'h0200_0000;
  localparam logic [ADDR_W-1:0] CHIPRAM_LO   = 32'h0300_0000;
  localparam logic [ADDR_W-1:0] IO_LO        = 32'h0400_0000;
  localparam logic [ADDR_W-1:0] VIDREG_END   = 32'h0400_0060;
  localparam logic [ADDR_W-1:0] DMA_LO       = 32'h0400_00B0;
  localparam logic [ADDR_W-1:0] DMA_END      = 32'h0400_00E0;
  localparam logic [ADDR_W-1:0] TIMER_LO     = 32'h0400_0100;
  localparam logic [ADDR_W-1:0] TIMER_END    = 32'h0400_0110;
  localparam logic [ADDR_W-1:0] KEYSTAT_LO   = 32'h0400_0130;
  localparam logic [ADDR_W-1:0] KEYCTL_LO    = 32'h0400_0132;
  localparam logic [ADDR_W-1:0] KEYCTL_END   = 32'h0400_0134;
  localparam logic [ADDR_W-1:0] IRQEN_LO     = 32'h0400_0200;
  localparam logic [ADDR_W-1:0] IRQFLAG_LO   = 32'h0400_0202;
  localparam logic [ADDR_W-1:0] WAIT_LO      = 32'h0400_0204;
  localparam logic [ADDR_W-1:0] IME_LO       = 32'h0400_0208;
  localparam logic [ADDR_W-1:0] IME_END      = 32'h0400_020C;
  localparam logic [ADDR_W-1:0] POST_ADDR    = 32'h0400_0300;
  localparam logic [ADDR_W-1:0] HALT_ADDR    = 32'h0400_0301;
  localparam logic [ADDR_W-1:0] MEMCTL_LO    = 32'h0400_0800;
  localparam logic [15:0]       MEMCTL_PAGE  = 16'h0800;
  localparam logic [ADDR_W-1:0] VIDMEM_LO    = 32'h0500_0000;
  localparam logic [ADDR_W-1:0] ROM_LO       = 32'h0800_0000;
  localparam logic [ADDR_W-1:0] ROM_END      = 32'h0E00_0000;
  localparam logic [ADDR_W-1:0] CART0_LO     = 32'h0E00_0000;
  localparam logic [ADDR_W-1:0] CART0_END    = 32'h0E01_0000;
  localparam logic [ADDR_W-1:0] CART1_LO     = 32'h0F00_0000;
  localparam logic [ADDR_W-1:0] CART1_END    = 32'h0F01_0000;

  localparam int DMA_STRIDE = 12;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic [1:0]       channel;
    logic [OFS_W-1:0] offset;
  } dec_t;

  // Offset of lane k inside a mirrored region, given the mirrored offset of
  // the access's first byte. When the low bits wrapped below k the byte has
  // crossed into the start of a new block, so its raw offset stands.
  function automatic logic [MIR_W-1:0] mirror_lane(input logic [MIR_W-1:0] base_mod,
                                                   input logic [MIR_W-1:0] off,
                                                   input logic [1:0]       k,
                                                   input logic [MIR_W:0]   size);
    logic [MIR_W:0] sum;
    sum = {1'b0, base_mod} + (MIR_W+1)'(k);
    if (off < MIR_W'(k)) begin
      return off;
    end
    if (sum >= size) begin
      sum = sum - size;
    end
    return sum[MIR_W-1:0];
  endfunction

endpackage

@@ sv/sbad_if.sv @@
// Valid/ready channel interfaces for the access input, the byte result
// output and the configuration write port. Depends on sbad_pkg.
interface sbad_in_if;
  import sbad_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              action;
  logic [1:0]        access_size;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, address, action, access_size, write_data, input ready);
  modport sink   (input valid, address, action, access_size, write_data, output ready);
endinterface

interface sbad_out_if;
  import sbad_pkg::*;
  logic              valid;
  logic              ready;
  logic [TGT_W-1:0]  target;
  logic [1:0]        channel;
  logic [OFS_W-1:0]  local_offset;
  logic [ADDR_W-1:0] byte_address;
  logic [7:0]        byte_data;
  logic [1:0]        lane;
  logic              last;

  modport source (output valid, target, channel, local_offset, byte_address, byte_data,
                  lane, last, input ready);
  modport sink   (input valid, target, channel, local_offset, byte_address, byte_data,
                  lane, last, output ready);
endinterface

interface sbad_cfg_if;
  import sbad_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/sbad_cmod.sv @@
// Two-stage remainder by a constant: reciprocal multiply, then multiply
// back, subtract and one correction. Standalone, no package needed.
module sbad_cmod #(
  parameter int DIVISOR = 1024,
  parameter int X_W     = 24
) (
  input  logic           clk,
  input  logic           ld_a,
  input  logic           ld_b,
  input  logic [X_W-1:0] x,
  output logic [X_W-1:0] rem
);
  localparam int RW    = X_W + 1;
  localparam int CW    = $clog2(DIVISOR + 1);
  localparam int EW    = ((X_W > CW) ? X_W : CW) + 1;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << X_W) / DIVISOR);
  localparam logic [CW-1:0] DIV_V = CW'(DIVISOR);

  logic [X_W-1:0]    x_r;
  logic [X_W+RW-1:0] prod_r;
  logic [X_W-1:0]    rem_r;
  logic [RW-1:0]     q;
  logic [RW+CW-1:0]  qc;
  logic [X_W-1:0]    r_est;
  logic [EW-1:0]     r_ext;
  logic [EW-1:0]     r_fix;

  // the estimate is low by at most one, so one subtract corrects it
  always_comb begin
    q     = prod_r[X_W +: RW];
    qc    = {{CW{1'b0}}, q} * {{RW{1'b0}}, DIV_V};
    r_est = x_r - qc[X_W-1:0];
    r_ext = EW'(r_est);
    r_fix = (r_ext >= EW'(DIV_V)) ? (r_ext - EW'(DIV_V)) : r_ext;
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      x_r    <= x;
      prod_r <= {{RW{1'b0}}, x} * {{X_W{1'b0}}, RECIP};
    end
    if (ld_b) begin
      rem_r <= r_fix[X_W-1:0];
    end
  end

  assign rem = rem_r;

endmodule

@@ sv/sbad_decode.sv @@
// Region decode of one byte address into target, channel and offset.
// Mirrored RAM offsets arrive already reduced. Depends on sbad_pkg.
module sbad_decode (
  input  logic [sbad_pkg::ADDR_W-1:0] addr,
  input  logic                        wr,
  input  logic [sbad_pkg::OFS_W-1:0]  rom_size,
  input  logic [sbad_pkg::MIR_W-1:0]  board_off,
  input  logic [sbad_pkg::MIR_W-1:0]  chip_off,
  input  logic [sbad_pkg::MIR_W-1:0]  cart_off,
  output sbad_pkg::dec_t              dec
);
  import sbad_pkg::*;

  logic [5:0]  dma_m;
  logic [3:0]  tmr_m;
  logic [24:0] rom_m;

  always_comb begin
    dma_m = 6'(addr - DMA_LO);
    tmr_m = 4'(addr - TIMER_LO);
    rom_m = addr[24:0];
    dec   = '{target: TGT_UNMAPPED, channel: 2'd0, offset: '0};

    if (addr < BOOTROM_END) begin
      if (!wr) dec = '{TGT_BOOTROM, 2'd0, OFS_W'(addr[13:0])};
    end else if (addr >= BOARDRAM_LO && addr < CHIPRAM_LO) begin
      dec = '{TGT_BOARDRAM, 2'd0, OFS_W'(board_off)};
    end else if (addr >= CHIPRAM_LO && addr < IO_LO) begin
      dec = '{TGT_CHIPRAM, 2'd0, OFS_W'(chip_off)};
    end else if (addr >= IO_LO && addr < VIDREG_END) begin
      dec = '{TGT_VIDREG, 2'd0, OFS_W'(addr[6:0])};
    end else if (addr >= DMA_LO && addr < DMA_END) begin
      // twelve bytes per channel
      if (dma_m >= 6'(3 * DMA_STRIDE)) begin
        dec = '{TGT_DMA, 2'd3, OFS_W'(dma_m - 6'(3 * DMA_STRIDE))};
      end else if (dma_m >= 6'(2 * DMA_STRIDE)) begin
        dec = '{TGT_DMA, 2'd2, OFS_W'(dma_m - 6'(2 * DMA_STRIDE))};
      end else if (dma_m >= 6'(DMA_STRIDE)) begin
        dec = '{TGT_DMA, 2'd1, OFS_W'(dma_m - 6'(DMA_STRIDE))};
      end else begin
        dec = '{TGT_DMA, 2'd0, OFS_W'(dma_m)};
      end
    end else if (addr >= TIMER_LO && addr < TIMER_END) begin
      dec = '{TGT_TIMER, tmr_m[3:2], OFS_W'(tmr_m[1:0])};
    end else if (addr >= KEYSTAT_LO && addr < KEYCTL_LO) begin
      if (!wr) dec = '{TGT_KEYSTAT, 2'd0, OFS_W'(addr[0])};
    end else if (addr >= KEYCTL_LO && addr < KEYCTL_END) begin
      dec = '{TGT_KEYCTL, 2'd0, OFS_W'(addr[0])};
    end else if (addr >= IRQEN_LO && addr < IRQFLAG_LO) begin
      dec = '{TGT_IRQEN, 2'd0, OFS_W'(addr[0])};
    end else if (addr >= IRQFLAG_LO && addr < WAIT_LO) begin
      dec = '{TGT_IRQFLAG, 2'd0, OFS_W'(addr[0])};
    end else if (addr >= WAIT_LO && addr < IME_LO) begin
      dec = '{TGT_WAIT, 2'd0, OFS_W'(addr[1:0])};
    end else if (addr >= IME_LO && addr < IME_END) begin
      dec = '{TGT_IME, 2'd0, OFS_W'(addr[1:0])};
    end else if (addr == POST_ADDR) begin
      dec = '{TGT_POST, 2'd0, '0};
    end else if (addr == HALT_ADDR) begin
      if (wr) dec = '{TGT_HALT, 2'd0, '0};
    end else if (addr >= MEMCTL_LO && addr < VIDMEM_LO) begin
      // mirrored every 64 KiB, four bytes at the page offset
      if (addr[15:2] == MEMCTL_PAGE[15:2]) dec = '{TGT_MEMCTL, 2'd0, OFS_W'(addr[1:0])};
    end else if (addr >= VIDMEM_LO && addr < ROM_LO) begin
      dec = '{TGT_VIDMEM, 2'd0, OFS_W'(addr - VIDMEM_LO)};
    end else if (addr >= ROM_LO && addr < ROM_END) begin
      if (!wr && (OFS_W'(rom_m) < rom_size)) dec = '{TGT_ROM, 2'd0, OFS_W'(rom_m)};
    end else if ((addr >= CART0_LO && addr < CART0_END) ||
                 (addr >= CART1_LO && addr < CART1_END)) begin
      dec = '{TGT_CARTRAM, 2'd0, OFS_W'(cart_off)};
    end
  end

endmodule

@@ sv/system_bus_address_decoder_unit.sv @@
// System bus address decoder. Each accepted access (byte, halfword or word,
// read or write) leaves as one, two or four byte results, one per cycle on
// the result channel while the receiver is ready, lanes in ascending order
// with last on the final one. The input takes a new access whenever stage A
// is empty or its access moves into the lane sequencer, which happens as the
// current access hands its final byte to the result register. The
// reciprocal multiply of the RAM mirroring is registered with the access in
// stage A, the multiply-back and correction as it moves into stage B, and
// each lane's decode into the output register. Write rom_size only while
// no access is in flight.
module system_bus_address_decoder_unit #(
  parameter int BOARD_RAM_BYTES = sbad_pkg::DEF_BOARD_RAM_BYTES,
  parameter int CHIP_RAM_BYTES  = sbad_pkg::DEF_CHIP_RAM_BYTES,
  parameter int CART_RAM_BYTES  = sbad_pkg::DEF_CART_RAM_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  sbad_in_if.sink           in_ch,
  sbad_out_if.source        out_ch,
  sbad_cfg_if.sink          cfg_ch
);
  import sbad_pkg::*;

  localparam int CART_W = 16;

  // configuration
  logic [OFS_W-1:0]  rom_size_r;

  // stage A: captured access
  logic              a_valid_r;
  logic [ADDR_W-1:0] a_addr_r;
  logic              a_wr_r;
  logic [1:0]        a_last_r;
  logic [DATA_W-1:0] a_data_r;

  // stage B: lane sequencer
  logic              b_valid_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic              b_wr_r;
  logic [1:0]        b_last_r;
  logic [DATA_W-1:0] b_data_r;
  logic [1:0]        lane_r;
  logic [1:0]        lane_nxt;

  // result register
  logic              out_valid_r;
  logic [TGT_W-1:0]  out_target_r;
  logic [1:0]        out_channel_r;
  logic [OFS_W-1:0]  out_offset_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [7:0]        out_data_r;
  logic [1:0]        out_lane_r;
  logic              out_last_r;

  logic              in_acc;
  logic              lane_last;
  logic              adv_out;
  logic              b_done;
  logic              b_free;
  logic              a_move;
  logic [1:0]        in_last;

  logic [MIR_W-1:0]  board_mod;
  logic [MIR_W-1:0]  chip_mod;
  logic [CART_W-1:0] cart_mod;
  logic [ADDR_W-1:0] byte_addr;
  logic [MIR_W-1:0]  board_off;
  logic [MIR_W-1:0]  chip_off;
  logic [MIR_W-1:0]  cart_off;
  dec_t              dec;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    lane_last = (lane_r == b_last_r);
    adv_out   = b_valid_r && (!out_valid_r || out_ch.ready);
    b_done    = adv_out && lane_last;
    b_free    = !b_valid_r || b_done;
    a_move    = a_valid_r && b_free;
    lane_nxt  = lane_r + 2'd1;
  end

  assign in_ch.ready  = !a_valid_r || a_move;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    unique case (in_ch.access_size)
      SZ_BYTE: in_last = 2'd0;
      SZ_HALF: in_last = 2'd1;
      default: in_last = 2'd3;
    endcase
  end

  sbad_cmod #(.DIVISOR(BOARD_RAM_BYTES), .X_W(MIR_W)) u_board_mod (
    .clk  (clk),
    .ld_a (in_acc),
    .ld_b (a_move),
    .x    (in_ch.address[MIR_W-1:0]),
    .rem  (board_mod)
  );

  sbad_cmod #(.DIVISOR(CHIP_RAM_BYTES), .X_W(MIR_W)) u_chip_mod (
    .clk  (clk),
    .ld_a (in_acc),
    .ld_b (a_move),
    .x    (in_ch.address[MIR_W-1:0]),
    .rem  (chip_mod)
  );

  sbad_cmod #(.DIVISOR(CART_RAM_BYTES), .X_W(CART_W)) u_cart_mod (
    .clk  (clk),
    .ld_a (in_acc),
    .ld_b (a_move),
    .x    (in_ch.address[CART_W-1:0]),
    .rem  (cart_mod)
  );

  always_comb begin
    byte_addr = b_addr_r + ADDR_W'(lane_r);
    board_off = mirror_lane(board_mod, byte_addr[MIR_W-1:0], lane_r,
                            (MIR_W+1)'(BOARD_RAM_BYTES));
    chip_off  = mirror_lane(chip_mod, byte_addr[MIR_W-1:0], lane_r,
                            (MIR_W+1)'(CHIP_RAM_BYTES));
    cart_off  = mirror_lane(MIR_W'(cart_mod), MIR_W'(byte_addr[CART_W-1:0]), lane_r,
                            (MIR_W+1)'(CART_RAM_BYTES));
  end

  sbad_decode u_decode (
    .addr      (byte_addr),
    .wr        (b_wr_r),
    .rom_size  (rom_size_r),
    .board_off (board_off),
    .chip_off  (chip_off),
    .cart_off  (cart_off),
    .dec       (dec)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_r  <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      lane_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        rom_size_r <= cfg_ch.data;
      end

      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end

      // load a fresh access or advance a lane per transfer into the result stage
      if (a_move) begin
        b_valid_r <= 1'b1;
        lane_r    <= 2'd0;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end else if (adv_out) begin
        lane_r <= lane_nxt;
      end

      if (adv_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_addr_r <= in_ch.address;
      a_wr_r   <= in_ch.action;
      a_last_r <= in_last;
      a_data_r <= in_ch.write_data;
    end
    if (a_move) begin
      b_addr_r <= a_addr_r;
      b_wr_r   <= a_wr_r;
      b_last_r <= a_last_r;
      b_data_r <= a_data_r;
    end
    if (adv_out) begin
      out_target_r  <= dec.target;
      out_channel_r <= dec.channel;
      out_offset_r  <= dec.offset;
      out_addr_r    <= byte_addr;
      out_data_r    <= b_wr_r ? b_data_r[{lane_r, 3'b000} +: 8] : 8'd0;
      out_lane_r    <= lane_r;
      out_last_r    <= lane_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.target       = out_target_r;
  assign out_ch.channel      = out_channel_r;
  assign out_ch.local_offset = out_offset_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.byte_data    = out_data_r;
  assign out_ch.lane         = out_lane_r;
  assign out_ch.last         = out_last_r;

  a_lane_step: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && adv_out && !lane_last) |=> (b_valid_r && lane_r == $past(lane_nxt)))
    else $error("lane sequencer skipped or repeated a lane");

  a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_free) |=> (a_valid_r && $stable(a_addr_r)))
    else $error("stage A lost its access while the sequencer was busy");

  a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (lane_r <= b_last_r))
    else $error("lane counter ran past the final lane");

  a_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lane_r == 2'd3) |-> out_last_r)
    else $error("lane three not marked last");

  a_rest_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> b_valid_r)
    else $error("access dropped before its final byte");

endmodule

@@ sim/system_bus_address_decoder_unit_tb.sv @@
// Testbench for the system bus address decoder: predicts every byte transfer
// of each accepted access and checks it. Depends on sbad_pkg, the channel
// interfaces and system_bus_address_decoder_unit.
`timescale 1ns / 100ps

module system_bus_address_decoder_unit_tb;
  import sbad_pkg::*;

  localparam logic [31:0] BOARD_MIRROR = DEF_BOARD_RAM_BYTES;
  localparam logic [31:0] CHIP_MIRROR  = DEF_CHIP_RAM_BYTES;
  localparam logic [31:0] CART_MIRROR  = DEF_CART_RAM_BYTES;
  localparam logic [31:0] ROM_WINDOW_MASK = 32'h01FF_FFFF;
  localparam int          NUM_MAP_EDGES   = 25;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          DRAIN_LIMIT     = 20000;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic              is_write;
    logic [1:0]        access_size;
    logic [DATA_W-1:0] write_data;
  } access_t;

  typedef struct {
    logic [TGT_W-1:0]  target;
    logic [1:0]        channel;
    logic [OFS_W-1:0]  local_offset;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        byte_data;
    logic [1:0]        lane;
    logic              last;
  } byte_res_t;

  logic clk;
  logic rst_n;

  sbad_in_if  in_if ();
  sbad_out_if out_if ();
  sbad_cfg_if cfg_if ();

  system_bus_address_decoder_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  access_t          pending_accesses[$];
  byte_res_t        predicted_bytes[$];
  logic [OFS_W-1:0] rom_size_now = '0;
  int               sender_idle_pct    = 0;
  int               receiver_stall_pct = 0;
  int               hold_cycles_left   = 0;
  int               error_count        = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** system_bus_address_decoder_unit: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] addr,
                                 input logic [31:0] got, input logic [31:0] want);
    if (error_count < 100) begin
      $display("%0t: byte 0x%08h %s: got 0x%0h, expected 0x%0h", $realtime, addr, what, got,
               want);
    end
    error_count++;
  endtask

  // Region, channel and mirrored offset of one byte address.
  function automatic dec_t decode_address(input logic [31:0] a, input logic wr,
                                          input logic [OFS_W-1:0] rom_sz);
    dec_t        d;
    logic [31:0] m;
    d = '{TGT_UNMAPPED, 2'd0, '0};
    if (a < BOOTROM_END) begin
      if (!wr) d = '{TGT_BOOTROM, 2'd0, OFS_W'(a)};
    end else if (a >= BOARDRAM_LO && a < CHIPRAM_LO) begin
      d = '{TGT_BOARDRAM, 2'd0, OFS_W'((a - BOARDRAM_LO) % BOARD_MIRROR)};
    end else if (a >= CHIPRAM_LO && a < IO_LO) begin
      d = '{TGT_CHIPRAM, 2'd0, OFS_W'((a - CHIPRAM_LO) % CHIP_MIRROR)};
    end else if (a >= IO_LO && a < VIDREG_END) begin
      d = '{TGT_VIDREG, 2'd0, OFS_W'(a - IO_LO)};
    end else if (a >= DMA_LO && a < DMA_END) begin
      m = a - DMA_LO;
      d = '{TGT_DMA, 2'(m / DMA_STRIDE), OFS_W'(m % DMA_STRIDE)};
    end else if (a >= TIMER_LO && a < TIMER_END) begin
      m = a - TIMER_LO;
      d = '{TGT_TIMER, m[3:2], OFS_W'(m[1:0])};
    end else if (a >= KEYSTAT_LO && a < KEYCTL_LO) begin
      if (!wr) d = '{TGT_KEYSTAT, 2'd0, OFS_W'(a - KEYSTAT_LO)};
    end else if (a >= KEYCTL_LO && a < KEYCTL_END) begin
      d = '{TGT_KEYCTL, 2'd0, OFS_W'(a - KEYCTL_LO)};
    end else if (a >= IRQEN_LO && a < IRQFLAG_LO) begin
      d = '{TGT_IRQEN, 2'd0, OFS_W'(a - IRQEN_LO)};
    end else if (a >= IRQFLAG_LO && a < WAIT_LO) begin
      d = '{TGT_IRQFLAG, 2'd0, OFS_W'(a - IRQFLAG_LO)};
    end else if (a >= WAIT_LO && a < IME_LO) begin
      d = '{TGT_WAIT, 2'd0, OFS_W'(a - WAIT_LO)};
    end else if (a >= IME_LO && a < IME_END) begin
      d = '{TGT_IME, 2'd0, OFS_W'(a - IME_LO)};
    end else if (a == POST_ADDR) begin
      d = '{TGT_POST, 2'd0, '0};
    end else if (a == HALT_ADDR) begin
      if (wr) d = '{TGT_HALT, 2'd0, '0};
    end else if (a >= MEMCTL_LO && a < VIDMEM_LO) begin
      // memory control repeats every 64 KB page
      m = {16'd0, a[15:0]};
      if (m >= MEMCTL_PAGE && m < MEMCTL_PAGE + 4) begin
        d = '{TGT_MEMCTL, 2'd0, OFS_W'(m - MEMCTL_PAGE)};
      end
    end else if (a >= VIDMEM_LO && a < ROM_LO) begin
      d = '{TGT_VIDMEM, 2'd0, OFS_W'(a - VIDMEM_LO)};
    end else if (a >= ROM_LO && a < ROM_END) begin
      m = a & ROM_WINDOW_MASK;
      if (!wr && m < {6'd0, rom_sz}) d = '{TGT_ROM, 2'd0, OFS_W'(m)};
    end else if ((a >= CART0_LO && a < CART0_END) || (a >= CART1_LO && a < CART1_END)) begin
      d = '{TGT_CARTRAM, 2'd0, OFS_W'({16'd0, a[15:0]} % CART_MIRROR)};
    end
    return d;
  endfunction

  task automatic predict_bytes(input access_t acc);
    int        n;
    dec_t      d;
    byte_res_t r;
    n = (acc.access_size == SZ_BYTE) ? 1 : (acc.access_size == SZ_HALF) ? 2 : 4;
    for (int k = 0; k < n; k++) begin
      r.byte_address = acc.address + 32'(k);
      d = decode_address(r.byte_address, acc.is_write, rom_size_now);
      r.target       = d.target;
      r.channel      = d.channel;
      r.local_offset = d.offset;
      r.byte_data    = acc.is_write ? acc.write_data[8*k +: 8] : 8'd0;
      r.lane         = 2'(k);
      r.last         = (k == n - 1);
      predicted_bytes.insert(predicted_bytes.size(), r);
    end
  endtask

  always @(posedge clk) begin : drive_accesses
    access_t acc;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        acc = '{in_if.address, in_if.action, in_if.access_size, in_if.write_data};
        predict_bytes(acc);
      end
      // hold the offered access until it transfers
      if (!in_if.valid || in_if.ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          acc = pending_accesses.pop_front();
          in_if.valid       <= 1'b1;
          in_if.address     <= acc.address;
          in_if.action      <= acc.is_write;
          in_if.access_size <= acc.access_size;
          in_if.write_data  <= acc.write_data;
        end else begin
          in_if.valid       <= 1'b0;
          in_if.address     <= $urandom();
          in_if.action      <= 1'($urandom());
          in_if.access_size <= 2'($urandom());
          in_if.write_data  <= $urandom();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
  end

  always @(posedge clk) begin : check_bytes
    byte_res_t got;
    byte_res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.target, out_if.channel, out_if.local_offset, out_if.byte_address,
                out_if.byte_data, out_if.lane, out_if.last};
        if (predicted_bytes.size() == 0) begin
          report_mismatch("unexpected transfer", got.byte_address, 32'(got.target), 32'd0);
        end else begin
          want = predicted_bytes.pop_front();
          if (got.byte_address !== want.byte_address)
            report_mismatch("byte_address", want.byte_address, got.byte_address,
                            want.byte_address);
          if (got.target !== want.target)
            report_mismatch("target", want.byte_address, 32'(got.target),
                            32'(want.target));
          if (got.channel !== want.channel)
            report_mismatch("channel", want.byte_address, 32'(got.channel),
                            32'(want.channel));
          if (got.local_offset !== want.local_offset)
            report_mismatch("local_offset", want.byte_address, 32'(got.local_offset),
                            32'(want.local_offset));
          if (got.byte_data !== want.byte_data)
            report_mismatch("byte_data", want.byte_address, 32'(got.byte_data),
                            32'(want.byte_data));
          if (got.lane !== want.lane)
            report_mismatch("lane", want.byte_address, 32'(got.lane), 32'(want.lane));
          if (got.last !== want.last)
            report_mismatch("last", want.byte_address, 32'(got.last), 32'(want.last));
        end
      end
      out_if.ready <= (hold_cycles_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic logic [31:0] map_edge(input int idx);
    case (idx)
      0:  return BOOTROM_END;
      1:  return BOARDRAM_LO;
      2:  return CHIPRAM_LO;
      3:  return IO_LO;
      4:  return VIDREG_END;
      5:  return DMA_LO;
      6:  return DMA_END;
      7:  return TIMER_LO;
      8:  return TIMER_END;
      9:  return KEYSTAT_LO;
      10: return KEYCTL_LO;
      11: return KEYCTL_END;
      12: return IRQEN_LO;
      13: return IRQFLAG_LO;
      14: return WAIT_LO;
      15: return IME_LO;
      16: return IME_END;
      17: return POST_ADDR;
      18: return MEMCTL_LO;
      19: return VIDMEM_LO;
      20: return ROM_LO;
      21: return ROM_END;
      22: return CART0_END;
      23: return CART1_LO;
      default: return CART1_END;
    endcase
  endfunction

  // Bias addresses towards region edges, mirror wraps and the loaded ROM end.
  function automatic logic [31:0] pick_address(input logic [OFS_W-1:0] rom_sz);
    logic [31:0] a;
    case ($urandom_range(0, 11))
      0:  a = $urandom();
      1:  a = $urandom_range(0, 32'h4003);
      2:  a = BOARDRAM_LO + ($urandom() & 32'h00FF_FFFF);
      3:  a = CHIPRAM_LO + ($urandom() & 32'h00FF_FFFF);
      4:  a = IO_LO + $urandom_range(0, 32'h320);
      5:  a = IO_LO | (($urandom() & 32'hFF) << 16) | $urandom_range(32'h7FC, 32'h807);
      6:  a = VIDMEM_LO + $urandom_range(0, 32'h02FF_FFFF);
      7: begin
        if ($urandom_range(0, 1) == 0)
          a = ROM_LO + ($urandom_range(0, 2) << 25) + {6'd0, rom_sz} - 32'd4
              + $urandom_range(0, 7);
        else
          a = ROM_LO + $urandom_range(0, 32'h05FF_FFFF);
      end
      8:  a = (($urandom_range(0, 1) == 0) ? CART0_LO : CART1_LO) + $urandom_range(0, 32'h10003);
      9:  a = map_edge($urandom_range(0, NUM_MAP_EDGES - 1)) + $urandom_range(0, 7) - 32'd4;
      10: a = 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: a = $urandom_range(32'h4000, 32'h01FF_FFFF);
    endcase
    return a;
  endfunction

  task automatic push_access(input logic [31:0] addr, input logic wr, input logic [1:0] sz,
                             input logic [31:0] data);
    access_t acc;
    acc = '{addr, wr, sz, data};
    pending_accesses.insert(pending_accesses.size(), acc);
  endtask

  task automatic push_directed_accesses();
    logic [31:0] rom_end_addr;
    rom_end_addr = ROM_LO + {6'd0, rom_size_now} - 32'd2;
    push_access(32'h0000_0000, 1'b1, 2'd0, 32'h0000_00A5);
    push_access(32'h0000_3FFE, 1'b0, 2'd2, 32'h0);
    push_access(32'hFFFF_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(32'hFFFF_FFFF, 1'b1, 2'd1, 32'hFFFF_FFFF);
    push_access(32'h0203_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(32'h02FF_FFFE, 1'b1, 2'd2, 32'h1234_5678);
    push_access(32'h0300_7FFE, 1'b0, 2'd2, 32'h0);
    push_access(32'h0400_005E, 1'b1, 2'd2, 32'h89AB_CDEF);
    push_access(32'h0400_00BA, 1'b0, 2'd2, 32'h0);
    push_access(32'h0400_00DE, 1'b1, 2'd2, 32'h00FF_00FF);
    push_access(32'h0400_010E, 1'b0, 2'd2, 32'h0);
    push_access(32'h0400_0130, 1'b0, 2'd2, 32'h0);
    push_access(32'h0400_0130, 1'b1, 2'd2, 32'hCAFE_F00D);
    push_access(32'h0400_0202, 1'b1, 2'd2, 32'h5566_7788);
    push_access(32'h0400_0206, 1'b0, 2'd2, 32'h0);
    push_access(32'h0400_0300, 1'b0, 2'd1, 32'h0);
    push_access(32'h0400_0300, 1'b1, 2'd1, 32'h0000_5A5A);
    push_access(32'h04FF_0800, 1'b1, 2'd2, 32'hDEAD_BEEF);
    push_access(32'h0400_07FE, 1'b0, 2'd2, 32'h0);
    push_access(32'h04FF_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(32'h07FF_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(rom_end_addr,  1'b0, 2'd2, 32'h0);
    push_access(32'h09FF_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(32'h0DFF_FFFE, 1'b0, 2'd2, 32'h0);
    push_access(32'h0E00_FFFE, 1'b1, 2'd2, 32'h0102_0304);
    push_access(32'h0F00_FFFE, 1'b0, 2'd2, 32'h0);
    // access size three behaves as a word
    push_access(32'h0400_0040, 1'b1, 2'd3, 32'hA1B2_C3D4);
  endtask

  task automatic write_rom_size(input logic [OFS_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    rom_size_now = value;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while ((pending_accesses.size() != 0 || in_if.valid || predicted_bytes.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (predicted_bytes.size() != 0)
      report_mismatch("results never arrived", predicted_bytes[0].byte_address,
                      32'(predicted_bytes.size()), 32'd0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [OFS_W-1:0] rom_sz, input int send_idle,
                           input int recv_stall, input int hold, input int count,
                           input bit with_directed);
    write_rom_size(rom_sz);
    @(negedge clk);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    hold_cycles_left   = hold;
    if (with_directed) push_directed_accesses();
    for (int i = 0; i < count; i++) begin
      push_access(pick_address(rom_size_now), 1'($urandom()), 2'($urandom()), $urandom());
    end
    wait_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.address     = '0;
    in_if.action      = 1'b0;
    in_if.access_size = SZ_BYTE;
    in_if.write_data  = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(26'h100_0002, 0, 0, 0, 40, 1'b1);
    // long receiver hold-off while the sender keeps offering
    run_phase(26'h3FF_FFFF, 0, 0, 300, 100, 1'b0);
    run_phase(OFS_W'($urandom_range(1, 32'h01FF_FFFF)), 52, 0, 0, 100, 1'b0);
    run_phase(26'h200_0000, 0, 52, 0, 100, 1'b0);
    run_phase(26'h000_0000, 13, 13, 0, 100, 1'b0);

    if (error_count == 0) begin
      $display("** system_bus_address_decoder_unit: PASSED **");
    end else begin
      $display("** system_bus_address_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
